>>> hdl/daltonize_color_matrix_defines.svh
// Assertion macros used by the top level of the colour matrix RTL.
`ifndef DALTONIZE_COLOR_MATRIX_DEFINES_SVH
`define DALTONIZE_COLOR_MATRIX_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("colour matrix check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("colour matrix check failed");

`endif

>>> hdl/dcm_pkg.sv
// Types, coefficient table and constants of the colour matrix pipeline.
package dcm_pkg;

  localparam int CHAN_W  = 8;
  localparam int COEF_W  = 10;
  localparam int PROD_W  = 18;
  localparam int RECIP_W = 19;
  localparam int MULW    = PROD_W + RECIP_W;
  localparam int QUO_W   = 9;

  // ceil(2^28 / 1000); exact floor division for every sum below 2^18.
  localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

  localparam logic [QUO_W-1:0] CHAN_MAX = 9'd255;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_DEUTER = 2'd1,
    MODE_PROTAN = 2'd2,
    MODE_TRITAN = 2'd3
  } colour_mode_t;

  // Rows give red, green and blue outputs; columns weigh red, green, blue inputs.
  localparam logic [COEF_W-1:0] COEF_TBL [0:3][0:8] = '{
    '{10'd1000, 10'd0,    10'd0,
      10'd0,    10'd1000, 10'd0,
      10'd0,    10'd0,    10'd1000},
    '{10'd800,  10'd200,  10'd0,
      10'd258,  10'd742,  10'd0,
      10'd0,    10'd142,  10'd858},
    '{10'd567,  10'd433,  10'd0,
      10'd558,  10'd442,  10'd0,
      10'd0,    10'd242,  10'd758},
    '{10'd950,  10'd50,   10'd0,
      10'd0,    10'd433,  10'd567,
      10'd0,    10'd475,  10'd525}
  };

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;
    logic              in_last;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              out_last;
  } pix_out_t;

  typedef struct packed {
    logic [8:0][PROD_W-1:0] prod;
    logic [CHAN_W-1:0]      alpha;
    logic                   last;
  } prod_word_t;

  typedef struct packed {
    logic [2:0][PROD_W-1:0] sum;
    logic [CHAN_W-1:0]      alpha;
    logic                   last;
  } sum_word_t;

  typedef struct packed {
    logic [2:0][QUO_W-1:0] quo;
    logic [CHAN_W-1:0]     alpha;
    logic                  last;
  } quo_word_t;

endpackage

>>> hdl/dcm_prod.sv
// First stage: the nine channel-by-coefficient products of the selected matrix.
module dcm_prod (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          mode,
  input  logic                up_valid,
  output logic                up_ready,
  input  dcm_pkg::pix_in_t    up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output dcm_pkg::prod_word_t dn_data
);

  logic                  vld_r;
  dcm_pkg::prod_word_t   data_r;
  dcm_pkg::prod_word_t   data_nxt;
  logic [2:0][dcm_pkg::CHAN_W-1:0] chan;

  assign chan     = {up_data.in_blue, up_data.in_green, up_data.in_red};
  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    data_nxt.alpha = up_data.in_alpha;
    data_nxt.last  = up_data.in_last;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        data_nxt.prod[3*r+c] = {{(dcm_pkg::PROD_W-dcm_pkg::CHAN_W){1'b0}}, chan[c]}
          * {{(dcm_pkg::PROD_W-dcm_pkg::COEF_W){1'b0}}, dcm_pkg::COEF_TBL[mode][3*r+c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

>>> hdl/dcm_rowsum.sv
// Second stage: adds the three products of each matrix row.
module dcm_rowsum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  dcm_pkg::prod_word_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output dcm_pkg::sum_word_t  dn_data
);

  logic               vld_r;
  dcm_pkg::sum_word_t data_r;
  dcm_pkg::sum_word_t data_nxt;

  assign up_ready = !vld_r || dn_ready;

  // Every row of coefficients adds up to the scale, so a sum never exceeds 255000.
  always_comb begin
    data_nxt.alpha = up_data.alpha;
    data_nxt.last  = up_data.last;
    for (int r = 0; r < 3; r++) begin
      data_nxt.sum[r] = up_data.prod[3*r] + up_data.prod[3*r+1] + up_data.prod[3*r+2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

>>> hdl/dcm_div.sv
// Third stage: divides each row sum by 1000 through a reciprocal multiplication.
module dcm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  dcm_pkg::sum_word_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output dcm_pkg::quo_word_t dn_data
);

  logic                         vld_r;
  dcm_pkg::quo_word_t           data_r;
  dcm_pkg::quo_word_t           data_nxt;
  logic [2:0][dcm_pkg::MULW-1:0] mul;

  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    data_nxt.alpha = up_data.alpha;
    data_nxt.last  = up_data.last;
    for (int r = 0; r < 3; r++) begin
      mul[r] = {{dcm_pkg::RECIP_W{1'b0}}, up_data.sum[r]}
             * {{dcm_pkg::PROD_W{1'b0}}, dcm_pkg::RECIP_1000};
      data_nxt.quo[r] = mul[r][dcm_pkg::MULW-1 -: dcm_pkg::QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

>>> hdl/daltonize_color_matrix.sv
// Top level of the RGBA colour matrix pipeline with its mode register.
// One pixel word is accepted per clock unless in_stall holds the input, and each gives one result word:
// the products, the row sums, the division by 1000 and the clamped output register each
// take one register stage, and every stage holds its word under stall while the stages
// before it keep filling. colour_mode selects off, deuteranopia, protanopia or tritanopia;
// it is written through the cfg port, which is always ready, and should be changed only
// when no pixel is in flight. Alpha and the last-pixel flag travel unchanged with the colours.
`include "daltonize_color_matrix_defines.svh"

module daltonize_color_matrix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dcm_pkg::pix_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dcm_pkg::pix_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);

  dcm_pkg::colour_mode_t colour_mode_r;

  logic                s1_ready, s1_valid, s2_ready, s2_valid, s3_ready, s3_valid;
  dcm_pkg::prod_word_t s1_data;
  dcm_pkg::sum_word_t  s2_data;
  dcm_pkg::quo_word_t  s3_data;

  logic              out_ready;
  logic              out_vld_r;
  dcm_pkg::pix_out_t out_r;
  dcm_pkg::pix_out_t out_nxt;

  logic pipe_full;
  logic quo_in_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_mode_r <= dcm_pkg::MODE_OFF;
    end else if (cfg_valid && cfg_ready) begin
      colour_mode_r <= dcm_pkg::colour_mode_t'(cfg_data);
    end
  end

  dcm_prod u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (colour_mode_r),
    .up_valid (in_valid),
    .up_ready (s1_ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_data  (s1_data)
  );

  dcm_rowsum u_rowsum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_data  (s2_data)
  );

  dcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (out_ready),
    .dn_data  (s3_data)
  );

  assign out_ready = !out_vld_r || !out_stall;
  assign in_stall  = !s1_ready;

  always_comb begin
    out_nxt.out_red   = (s3_data.quo[0] > dcm_pkg::CHAN_MAX) ? 8'hFF : s3_data.quo[0][7:0];
    out_nxt.out_green = (s3_data.quo[1] > dcm_pkg::CHAN_MAX) ? 8'hFF : s3_data.quo[1][7:0];
    out_nxt.out_blue  = (s3_data.quo[2] > dcm_pkg::CHAN_MAX) ? 8'hFF : s3_data.quo[2][7:0];
    out_nxt.out_alpha = s3_data.alpha;
    out_nxt.out_last  = s3_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ready) begin
      out_vld_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s3_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign pipe_full    = s1_valid && s2_valid && s3_valid && out_vld_r && out_stall;
  assign quo_in_range = (s3_data.quo[0] <= dcm_pkg::CHAN_MAX)
                     && (s3_data.quo[1] <= dcm_pkg::CHAN_MAX)
                     && (s3_data.quo[2] <= dcm_pkg::CHAN_MAX);

  // Input stalls only when every stage holds a word and the output is blocked.
  `DCM_ASSERT_NOW(a_stall_full, in_stall, pipe_full)
  // An accepted pixel is held in the first stage on the following edge.
  `DCM_ASSERT_NEXT(a_accept_s1, in_valid && !in_stall, s1_valid)
  // Row sums never exceed 255000, so no quotient ever needs the clamp.
  `DCM_ASSERT_NOW(a_quo_range, s3_valid, quo_in_range)

endmodule
